// ----- src/cbm_pkg.sv -----
package cbm_pkg;

  localparam int unsigned ROM_BANK_BYTES = 16384;
  localparam int unsigned RAM_BANK_BYTES = 8192;
  localparam int unsigned ROM_OFS_W      = $clog2(ROM_BANK_BYTES);
  localparam int unsigned RAM_OFS_W      = $clog2(RAM_BANK_BYTES);

  localparam int unsigned ADDR_W         = 16;
  localparam int unsigned DATA_W         = 8;
  localparam int unsigned CART_ADDR_W    = 21;
  localparam int unsigned ROM_BANK_W     = 7;
  localparam int unsigned RAM_BANK_W     = 2;
  localparam int unsigned KIND_W         = 2;

  localparam int unsigned PADDR_W        = 3;
  localparam int unsigned PDATA_W        = 32;

  typedef logic [PADDR_W-2-1:0] reg_index_t;
  localparam reg_index_t REG_MAPPER_KIND = '0;

  typedef enum logic [KIND_W-1:0] {
    MAP_NONE = 2'd0,
    MAP_MBC1 = 2'd1,
    MAP_MBC2 = 2'd2
  } mapper_kind_t;

  typedef enum logic [1:0] {
    TGT_NONE = 2'd0,
    TGT_ROM  = 2'd1,
    TGT_RAM  = 2'd2
  } target_t;

  localparam logic [3:0] RAM_ENABLE_CODE  = 4'hA;
  localparam logic [3:0] RAM_DISABLE_CODE = 4'h0;

endpackage

// ----- src/cbm_if.sv -----
interface cbm_req_if;
  import cbm_pkg::*;

  logic              valid;
  logic              ready;
  logic              action;
  logic [ADDR_W-1:0] bus_address;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, action, bus_address, write_data, input ready);
  modport sink   (input valid, action, bus_address, write_data, output ready);
endinterface

interface cbm_rsp_if;
  import cbm_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [1:0]             target;
  logic [CART_ADDR_W-1:0] cart_address;
  logic                   ram_write;
  logic [DATA_W-1:0]      data_out;

  modport source (output valid, target, cart_address, ram_write, data_out, input ready);
  modport sink   (input valid, target, cart_address, ram_write, data_out, output ready);
endinterface

// ----- src/cartridge_bank_mapper.sv -----
// Cartridge bank mapper: translates one CPU bus request per cycle into a
// physical ROM or RAM address for MBC1, MBC2 or mapper-less cartridges, and
// turns writes below 0x8000 into bank register updates. Requests pass through
// an input register and a result register: an accepted request moves from the
// input register into the result register when that one is empty or its result
// is taken, and a new request may be accepted in every cycle; the throughput is
// one request per cycle, limited only by the result consumer. Bank registers are
// updated in request order as each request moves into the result register.
// The user writes mapper_kind over the APB port at address 0 and must do so only
// while no request is in flight; the block itself does not enforce this.
module cartridge_bank_mapper (
  input  logic                                 clk,
  input  logic                                 rst,
  cbm_req_if.sink                              req,
  cbm_rsp_if.source                            rsp,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [cbm_pkg::PADDR_W-1:0]          paddr,
  input  logic [cbm_pkg::PDATA_W-1:0]          pwdata,
  output logic [cbm_pkg::PDATA_W-1:0]          prdata,
  output logic                                 pready
);
  import cbm_pkg::*;

  typedef enum logic [1:0] {
    REGION_RAM_ENABLE = 2'd0,
    REGION_ROM_LOW    = 2'd1,
    REGION_ROM_HIGH   = 2'd2,
    REGION_MODE       = 2'd3
  } reg_region_t;

  logic [KIND_W-1:0]     mapper_kind;
  logic [ROM_BANK_W-1:0] rom_bank;
  logic [ROM_BANK_W-1:0] rom_bank_next;
  logic [RAM_BANK_W-1:0] ram_bank;
  logic [RAM_BANK_W-1:0] ram_bank_next;
  logic                  ram_enabled;
  logic                  ram_enabled_next;
  logic                  rom_bank_mode;
  logic                  rom_bank_mode_next;

  logic                  in_valid;
  logic                  in_action;
  logic [ADDR_W-1:0]     in_address;
  logic [DATA_W-1:0]     in_data;

  logic                   out_valid;
  logic [1:0]             out_target;
  logic [CART_ADDR_W-1:0] out_address;
  logic                   out_ram_write;
  logic [DATA_W-1:0]      out_data;

  logic [1:0]             res_target;
  logic [CART_ADDR_W-1:0] res_address;
  logic                   res_ram_write;
  logic [DATA_W-1:0]      res_data;

  logic advance;
  logic accept;
  logic is_mbc1;
  logic is_mbc2;
  logic cfg_write;

  function automatic logic [ROM_BANK_W-1:0] fix_zero_bank(input logic [ROM_BANK_W-1:0] bank);
    fix_zero_bank = (bank == '0) ? ROM_BANK_W'(1) : bank;
  endfunction

  assign advance   = !out_valid || rsp.ready;
  assign req.ready = !in_valid || advance;
  assign accept    = req.valid && req.ready;
  assign is_mbc1   = (mapper_kind == MAP_MBC1);
  assign is_mbc2   = (mapper_kind == MAP_MBC2);

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite
                     && (paddr[PADDR_W-1:2] == REG_MAPPER_KIND);
  assign prdata    = (paddr[PADDR_W-1:2] == REG_MAPPER_KIND)
                     ? PDATA_W'(mapper_kind) : '0;

  always_comb begin
    res_target    = TGT_NONE;
    res_address   = '0;
    res_ram_write = 1'b0;
    res_data      = '0;
    if (!in_address[ADDR_W-1]) begin
      if (!in_action) begin
        res_target = TGT_ROM;
        if (!in_address[ROM_OFS_W] || !(is_mbc1 || is_mbc2)) begin
          res_address = CART_ADDR_W'(in_address);
        end else begin
          res_address = {rom_bank, in_address[ROM_OFS_W-1:0]};
        end
      end
    end else if (in_address[ADDR_W-1:RAM_OFS_W] == 3'b101) begin
      res_target  = TGT_RAM;
      res_address = CART_ADDR_W'({ram_bank, in_address[RAM_OFS_W-1:0]});
      if (in_action && ram_enabled) begin
        res_ram_write = 1'b1;
        res_data      = in_data;
      end
    end
  end

  always_comb begin
    rom_bank_next      = rom_bank;
    ram_bank_next      = ram_bank;
    ram_enabled_next   = ram_enabled;
    rom_bank_mode_next = rom_bank_mode;
    if (in_action && !in_address[ADDR_W-1]) begin
      unique case (reg_region_t'(in_address[ADDR_W-2:RAM_OFS_W]))
        REGION_RAM_ENABLE: begin
          if (is_mbc1 || (is_mbc2 && !in_address[4])) begin
            if (in_data[3:0] == RAM_ENABLE_CODE) begin
              ram_enabled_next = 1'b1;
            end else if (in_data[3:0] == RAM_DISABLE_CODE) begin
              ram_enabled_next = 1'b0;
            end
          end
        end
        REGION_ROM_LOW: begin
          if (is_mbc2) begin
            rom_bank_next = fix_zero_bank(ROM_BANK_W'(in_data[3:0]));
          end else if (is_mbc1) begin
            rom_bank_next = fix_zero_bank({rom_bank[ROM_BANK_W-1:5], in_data[4:0]});
          end
        end
        REGION_ROM_HIGH: begin
          if (is_mbc1) begin
            if (rom_bank_mode) begin
              rom_bank_next = fix_zero_bank({in_data[1:0], rom_bank[4:0]});
            end else begin
              ram_bank_next = in_data[RAM_BANK_W-1:0];
            end
          end
        end
        REGION_MODE: begin
          if (is_mbc1) begin
            rom_bank_mode_next = !in_data[0];
            if (!in_data[0]) begin
              ram_bank_next = '0;
            end
          end
        end
        default: begin
          rom_bank_next = rom_bank;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mapper_kind   <= MAP_NONE;
      rom_bank      <= ROM_BANK_W'(1);
      ram_bank      <= '0;
      ram_enabled   <= 1'b0;
      rom_bank_mode <= 1'b0;
      in_valid      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        mapper_kind <= pwdata[KIND_W-1:0];
      end
      if (advance) begin
        out_valid <= in_valid;
        if (in_valid) begin
          rom_bank      <= rom_bank_next;
          ram_bank      <= ram_bank_next;
          ram_enabled   <= ram_enabled_next;
          rom_bank_mode <= rom_bank_mode_next;
        end
      end
      if (req.ready) begin
        in_valid <= req.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_action  <= req.action;
      in_address <= req.bus_address;
      in_data    <= req.write_data;
    end
    if (advance && in_valid) begin
      out_target    <= res_target;
      out_address   <= res_address;
      out_ram_write <= res_ram_write;
      out_data      <= res_data;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.target       = out_target;
  assign rsp.cart_address = out_address;
  assign rsp.ram_write    = out_ram_write;
  assign rsp.data_out     = out_data;

endmodule

// ----- src/cbm_checker.sv -----
module cbm_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  rsp_valid,
  input logic                                  rsp_ready,
  input logic [1:0]                            target,
  input logic [cbm_pkg::CART_ADDR_W-1:0]       cart_address,
  input logic                                  ram_write,
  input logic [cbm_pkg::DATA_W-1:0]            data_out
);
  import cbm_pkg::*;

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(target) && $stable(cart_address)
      && $stable(ram_write) && $stable(data_out))
    else $error("Stalled result changed.");

  assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("Result valid right after reset.");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && ram_write |-> target == TGT_RAM)
    else $error("RAM write outside the RAM window.");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !ram_write |-> data_out == '0)
    else $error("Write data shown without a RAM write.");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && target == TGT_NONE |-> cart_address == '0 && !ram_write)
    else $error("Non-cartridge result carries an address.");

endmodule

bind cartridge_bank_mapper cbm_checker u_cbm_checker (
  .clk          (clk),
  .rst          (rst),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .target       (rsp.target),
  .cart_address (rsp.cart_address),
  .ram_write    (rsp.ram_write),
  .data_out     (rsp.data_out)
);

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import cbm_pkg::*;

  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;
  localparam logic [KIND_W-1:0] MAP_UNKNOWN = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned RANDOM_PHASES = 12;
  localparam int unsigned PHASE_REQUESTS = 150;

  typedef struct packed {
    target_t                target;
    logic [CART_ADDR_W-1:0] cart_address;
    logic                   ram_write;
    logic [DATA_W-1:0]      data_out;
  } access_result_t;

  class bank_map_predictor;
    logic [KIND_W-1:0]     mapper_kind = MAP_NONE;
    logic [ROM_BANK_W-1:0] rom_bank = 7'd1;
    logic [RAM_BANK_W-1:0] ram_bank = '0;
    logic                  ram_enabled = 1'b0;
    logic                  rom_mode = 1'b0;
    access_result_t        expected_results[$];
    int unsigned           mismatches = 0;
    int unsigned           rom_hits = 0;
    int unsigned           ram_hits = 0;
    int unsigned           ram_stores = 0;
    int unsigned           other_hits = 0;

    function void update_banks(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
      logic is1;
      logic is2;
      is1 = (mapper_kind == MAP_MBC1);
      is2 = (mapper_kind == MAP_MBC2);
      if (addr < 16'h2000) begin
        if ((is1 || is2) && !(is2 && addr[4])) begin
          if (data[3:0] == RAM_ENABLE_CODE) ram_enabled = 1'b1;
          else if (data[3:0] == RAM_DISABLE_CODE) ram_enabled = 1'b0;
        end
      end else if (addr < 16'h4000) begin
        if (is2) rom_bank = {3'b000, data[3:0]};
        else if (is1) rom_bank = {rom_bank[6:5], data[4:0]};
        if (rom_bank == '0) rom_bank = 7'd1;
      end else if (addr < 16'h6000) begin
        if (is1) begin
          if (rom_mode) begin
            rom_bank = {data[1:0], rom_bank[4:0]};
            if (rom_bank == '0) rom_bank = 7'd1;
          end else begin
            ram_bank = data[1:0];
          end
        end
      end else if (is1) begin
        rom_mode = ~data[0];
        if (rom_mode) ram_bank = '0;
      end
    endfunction

    function void note_request(logic action, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
      access_result_t r;
      r = '0;
      r.target = TGT_NONE;
      if (addr < 16'h8000) begin
        if (action == ACT_WRITE) begin
          update_banks(addr, data);
        end else begin
          r.target = TGT_ROM;
          if (addr < 16'h4000 || (mapper_kind != MAP_MBC1 && mapper_kind != MAP_MBC2))
            r.cart_address = CART_ADDR_W'(addr);
          else
            r.cart_address = {rom_bank, addr[ROM_OFS_W-1:0]};
        end
      end else if (addr >= 16'hA000 && addr < 16'hC000) begin
        r.target = TGT_RAM;
        r.cart_address = CART_ADDR_W'({ram_bank, addr[RAM_OFS_W-1:0]});
        if (action == ACT_WRITE && ram_enabled) begin
          r.ram_write = 1'b1;
          r.data_out = data;
        end
      end
      expected_results = {expected_results, r};
    endfunction

    function void check_result(logic [1:0] target, logic [CART_ADDR_W-1:0] cart_address,
                               logic ram_write, logic [DATA_W-1:0] data_out);
      access_result_t e;
      if (expected_results.size() == 0) begin
        $display("%0t: result with no request waiting, target %0d address %0h", $time,
                 target, cart_address);
        mismatches++;
        return;
      end
      e = expected_results.pop_front();
      if (target !== e.target) begin
        $display("%0t: target expected %0d, actual %0d", $time, e.target, target);
        mismatches++;
      end
      if (cart_address !== e.cart_address) begin
        $display("%0t: cart_address expected %0h, actual %0h", $time, e.cart_address,
                 cart_address);
        mismatches++;
      end
      if (ram_write !== e.ram_write) begin
        $display("%0t: ram_write expected %0b, actual %0b", $time, e.ram_write, ram_write);
        mismatches++;
      end
      if (data_out !== e.data_out) begin
        $display("%0t: data_out expected %0h, actual %0h", $time, e.data_out, data_out);
        mismatches++;
      end
      case (e.target)
        TGT_ROM: rom_hits++;
        TGT_RAM: begin
          ram_hits++;
          if (e.ram_write) ram_stores++;
        end
        default: other_hits++;
      endcase
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;
  logic                 rsp_calm;
  int unsigned          stall_left;
  int unsigned          cycles;
  int unsigned          requests_sent;
  int unsigned          settings_used;
  bank_map_predictor    tracker = new();

  cbm_req_if req_bus ();
  cbm_rsp_if rsp_bus ();

  cartridge_bank_mapper DUT (
    .clk     (clk),
    .rst     (rst),
    .req     (req_bus),
    .rsp     (rsp_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned gap_len(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.", cycles,
               tracker.expected_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_bus.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready)
        tracker.check_result(rsp_bus.target, rsp_bus.cart_address, rsp_bus.ram_write,
                             rsp_bus.data_out);
      if (stall_left != 0) begin
        rsp_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_bus.ready <= 1'b1;
        stall_left = gap_len(rsp_calm);
      end
    end
  end

  task automatic send_request(input logic action, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] data, input int unsigned gap);
    req_bus.valid       <= 1'b1;
    req_bus.action      <= action;
    req_bus.bus_address <= addr;
    req_bus.write_data  <= data;
    do @(posedge clk); while (!req_bus.ready);
    tracker.note_request(action, addr, data);
    requests_sent++;
    if (gap != 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_requests();
    if (req_bus.valid) req_bus.valid <= 1'b0;
    while (tracker.expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_mapper(input logic [KIND_W-1:0] kind);
    drain_requests();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_MAPPER_KIND, 2'b00};
    pwdata  <= PDATA_W'(kind);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.mapper_kind = kind;
    settings_used++;
  endtask

  task automatic random_request(input bit calm);
    int unsigned       pick;
    logic              act;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    pick = $urandom_range(0, 99);
    act  = 1'($urandom_range(0, 1));
    data = 8'($urandom_range(0, 255));
    if (pick < 35) begin
      act  = ACT_WRITE;
      addr = 16'($urandom_range(0, 16'h7FFF));
      if (addr < 16'h2000 && $urandom_range(0, 1))
        data[3:0] = $urandom_range(0, 1) ? RAM_ENABLE_CODE : RAM_DISABLE_CODE;
    end else if (pick < 55) begin
      act  = ACT_READ;
      addr = 16'($urandom_range(0, 16'h7FFF));
    end else if (pick < 85) begin
      addr = 16'($urandom_range(16'hA000, 16'hBFFF));
    end else if (pick < 92) begin
      addr = 16'($urandom_range(16'h8000, 16'h9FFF));
    end else begin
      addr = 16'($urandom_range(16'hC000, 16'hFFFF));
    end
    send_request(act, addr, data, gap_len(calm));
  endtask

  initial begin
    logic [KIND_W-1:0] kind_pool[6];
    bit                calm;
    kind_pool = '{MAP_MBC1, MAP_MBC2, MAP_MBC1, MAP_MBC2, MAP_NONE, MAP_UNKNOWN};
    rst = 1'b1;
    req_bus.valid = 1'b0;
    req_bus.action = ACT_READ;
    req_bus.bus_address = '0;
    req_bus.write_data = '0;
    rsp_bus.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rsp_calm = 1'b0;
    stall_left = 0;
    cycles = 0;
    requests_sent = 0;
    settings_used = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    set_mapper(MAP_MBC1);
    send_request(ACT_READ,  16'h0000, 8'h00, gap_len(0));
    send_request(ACT_READ,  16'h3FFF, 8'hFF, gap_len(0));
    send_request(ACT_READ,  16'h4000, 8'h00, gap_len(0));
    send_request(ACT_WRITE, 16'h0000, 8'h0A, gap_len(0));
    send_request(ACT_WRITE, 16'hA000, 8'hFF, gap_len(0));
    send_request(ACT_WRITE, 16'h2000, 8'h00, gap_len(0));
    send_request(ACT_READ,  16'h7FFF, 8'h00, gap_len(0));
    send_request(ACT_WRITE, 16'h3FFF, 8'hFF, gap_len(0));
    send_request(ACT_WRITE, 16'h5FFF, 8'h03, gap_len(0));
    send_request(ACT_READ,  16'hBFFF, 8'h00, gap_len(0));
    send_request(ACT_WRITE, 16'h6000, 8'hFE, gap_len(0));
    send_request(ACT_WRITE, 16'h4000, 8'hFF, gap_len(0));
    send_request(ACT_WRITE, 16'h2000, 8'hE0, gap_len(0));
    send_request(ACT_READ,  16'h7FFF, 8'h00, gap_len(0));
    send_request(ACT_WRITE, 16'h7FFF, 8'h01, gap_len(0));
    send_request(ACT_WRITE, 16'h1FFF, 8'hF0, gap_len(0));
    send_request(ACT_WRITE, 16'hA123, 8'h5A, gap_len(0));
    send_request(ACT_READ,  16'h8000, 8'h00, gap_len(0));
    send_request(ACT_WRITE, 16'h9FFF, 8'hAA, gap_len(0));
    send_request(ACT_READ,  16'hC000, 8'h00, gap_len(0));
    send_request(ACT_WRITE, 16'hFFFF, 8'hFF, gap_len(0));
    set_mapper(MAP_MBC2);
    send_request(ACT_WRITE, 16'h0010, 8'h0A, gap_len(0));
    send_request(ACT_WRITE, 16'hA000, 8'h11, gap_len(0));
    send_request(ACT_WRITE, 16'h0000, 8'h0A, gap_len(0));
    send_request(ACT_WRITE, 16'h2000, 8'hF0, gap_len(0));
    send_request(ACT_WRITE, 16'h3000, 8'h0F, gap_len(0));
    send_request(ACT_WRITE, 16'h4000, 8'h03, gap_len(0));
    send_request(ACT_READ,  16'h4ABC, 8'h00, gap_len(0));
    set_mapper(MAP_NONE);
    send_request(ACT_WRITE, 16'h2000, 8'h05, gap_len(0));
    send_request(ACT_READ,  16'h5000, 8'h00, gap_len(0));
    set_mapper(MAP_UNKNOWN);
    send_request(ACT_READ,  16'h6123, 8'h00, gap_len(0));
    send_request(ACT_WRITE, 16'hB000, 8'h77, gap_len(0));

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      calm = (p % 4 == 3);
      set_mapper(p < 4 ? kind_pool[p] : kind_pool[$urandom_range(0, 5)]);
      rsp_calm = calm;
      for (int i = 0; i < PHASE_REQUESTS; i++) begin
        if ($urandom_range(0, 199) == 0) drain_requests();
        random_request(calm);
      end
    end

    rsp_calm = 1'b0;
    drain_requests();
    repeat (8) @(posedge clk);
    $display("Sent %0d requests over %0d mapper settings in %0d cycles.", requests_sent,
             settings_used, cycles);
    $display("Results: %0d ROM, %0d RAM with %0d stores, %0d register or unmapped.",
             tracker.rom_hits, tracker.ram_hits, tracker.ram_stores, tracker.other_hits);
    if (tracker.mismatches == 0 && tracker.expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/cbm_pkg.sv
src/cbm_if.sv
src/cartridge_bank_mapper.sv
src/cbm_checker.sv
sim/tb.sv
